/* design/two_key_min_heap_queue_top_defines.svh */
// ----------------------------------------------------------------------------
// two_key_min_heap_queue_top_defines.svh
// Assertion macros used by the heap queue top module.
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define TWO_KEY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TKMHQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TKMHQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tkmhq_pkg.sv */
// ----------------------------------------------------------------------------
// tkmhq_pkg
// Types, widths and codes of the two-key min-heap queue.
// ----------------------------------------------------------------------------
package tkmhq_pkg;

	localparam int HEAP_DEPTH = 64;
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);   // holds 0..HEAP_DEPTH
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);       // store address, pos - 1
	localparam int CAP_W      = 7;
	localparam int FILL_W     = 7;
	localparam int WIDE_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int SLOT_W     = 40;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] treatment;
		logic [15:0] tag;
	} slot_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  entry_priority;
		logic [15:0] entry_treatment;
		logic [15:0] entry_tag;
	} request_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [7:0]        out_priority;
		logic [15:0]       out_treatment;
		logic [15:0]       out_tag;
		logic [FILL_W-1:0] fill_count;
	} result_t;

endpackage

/* design/tkmhq_ram.sv */
// ----------------------------------------------------------------------------
// tkmhq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tkmhq_ram #(
	parameter int DATA_W = 40,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/tkmhq_key_cmp.sv */
// ----------------------------------------------------------------------------
// tkmhq_key_cmp
// Strict (priority, treatment) less-than, the shared compare unit.
// ----------------------------------------------------------------------------
module tkmhq_key_cmp import tkmhq_pkg::*; (
	input  slot_t a,
	input  slot_t b,
	output logic  less
);

	// priority in the high bits, so one 24-bit compare covers both keys
	assign less = {a.prio, a.treatment} < {b.prio, b.treatment};

endmodule

/* design/two_key_min_heap_queue_top.sv */
// ----------------------------------------------------------------------------
// two_key_min_heap_queue_top
// Binary min-heap priority queue keyed by priority, then treatment.
// ----------------------------------------------------------------------------
//
//  channel   ports                          rule
//  -------   -----------------------------  ---------------------------------
//  request   start, busy, request           taken when start && !busy
//  result    done, result                   one-cycle strobe, cannot stall
//  config    cfg_we, cfg_wdata              capacity written when cfg_we
//
// Push: an entry that reaches the root is written there; each level climbed
// takes a parent read, then a compare and move. Pop: read the root, latch
// it and read the last entry, latch the last entry; then each level going
// down reads the left child, reads the right child with the left compare,
// and does the right compare. The single read port of the entry store and
// the one shared key comparator force these steps to run one after another.
// Full push and empty pop are decided in the accept cycle and never go busy.
// Reset empties the queue and sets capacity to 64; the store is not cleared.
// done is a registered strobe; results are never held.
//
module two_key_min_heap_queue_top import tkmhq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  request_t         request,
	output logic             done,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

`include "two_key_min_heap_queue_top_defines.svh"

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_UP     = 4'd1;  // place at root or read parent
	localparam logic [3:0] S_UP_C   = 4'd2;  // compare with parent
	localparam logic [3:0] S_P_ROOT = 4'd3;  // read root
	localparam logic [3:0] S_P_LAST = 4'd4;  // latch root, read last
	localparam logic [3:0] S_P_MOVE = 4'd5;  // latch last as the moving entry
	localparam logic [3:0] S_DN     = 4'd6;  // read left child or settle
	localparam logic [3:0] S_DN_LC  = 4'd7;  // compare left, read right
	localparam logic [3:0] S_DN_RC  = 4'd8;  // compare right, move

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pos_q;
	logic [CAP_W-1:0] cap_q;
	slot_t            cur_q;        // entry being sifted (hole method)
	slot_t            best_q;       // winner of node vs left child
	logic             best_left_q;
	slot_t            root_q;       // popped entry
	logic             done_q;
	result_t          result_q;

	// store
	logic              we;
	logic [ADDR_W-1:0] waddr;
	slot_t             wdata;
	logic [ADDR_W-1:0] raddr;
	logic [SLOT_W-1:0] rdata_raw;
	slot_t             rdata;

	// shared comparator
	slot_t cmp_a;
	slot_t cmp_b;
	logic  cmp_less;

	// child positions, one bit wider so 2*pos never wraps
	logic [CNT_W:0]   left_w;
	logic [CNT_W:0]   right_w;
	logic [CNT_W:0]   cnt_w;
	logic [CNT_W-1:0] parent;
	logic             has_left;
	logic             has_right;

	// capacity check
	logic [WIDE_W-1:0] cap_eff;
	logic              full;

	assign left_w    = {pos_q, 1'b0};
	assign right_w   = left_w + 1'b1;
	assign cnt_w     = {1'b0, cnt_q};
	assign parent    = pos_q >> 1;
	assign has_left  = left_w <= cnt_w;
	assign has_right = right_w <= cnt_w;
	assign rdata     = slot_t'(rdata_raw);

	assign cap_eff = (WIDE_W'(cap_q) < WIDE_W'(HEAP_DEPTH)) ? WIDE_W'(cap_q)
	                                                        : WIDE_W'(HEAP_DEPTH);
	assign full    = WIDE_W'(cnt_q) >= cap_eff;

	tkmhq_ram #(
		.DATA_W (SLOT_W),
		.DEPTH  (HEAP_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	tkmhq_key_cmp u_cmp (
		.a    (cmp_a),
		.b    (cmp_b),
		.less (cmp_less)
	);

	// comparator operands
	always_comb begin
		cmp_a = cur_q;
		cmp_b = rdata;
		case (state_q)
			S_UP_C: begin
				cmp_a = cur_q;
				cmp_b = rdata;
			end
			S_DN_LC: begin
				cmp_a = rdata;
				cmp_b = cur_q;
			end
			S_DN_RC: begin
				cmp_a = rdata;
				cmp_b = best_q;
			end
			default: begin
				cmp_a = cur_q;
				cmp_b = rdata;
			end
		endcase
	end

	// read address: positions are 1-based, store addresses 0-based
	always_comb begin
		raddr = '0;
		case (state_q)
			S_UP:     raddr = ADDR_W'(parent - 1'b1);
			S_P_ROOT: raddr = '0;
			S_P_LAST: raddr = ADDR_W'(cnt_q - 1'b1);
			S_DN:     raddr = ADDR_W'(left_w - 1'b1);
			S_DN_LC:  raddr = ADDR_W'(right_w - 1'b1);
			default:  raddr = '0;
		endcase
	end

	// write port: every move writes the displaced entry into the hole at pos
	always_comb begin
		we    = 1'b0;
		waddr = ADDR_W'(pos_q - 1'b1);
		wdata = cur_q;
		case (state_q)
			S_UP: begin
				if (pos_q == CNT_W'(1)) begin
					we = 1'b1;
				end
			end
			S_UP_C: begin
				we    = 1'b1;
				wdata = cmp_less ? rdata : cur_q;
			end
			S_DN: begin
				we = !has_left;
			end
			S_DN_LC: begin
				if (!has_right) begin
					we    = 1'b1;
					wdata = cmp_less ? rdata : cur_q;
				end
			end
			S_DN_RC: begin
				we = 1'b1;
				if (cmp_less) begin
					wdata = rdata;
				end else begin
					wdata = best_q;  // cur_q when the node itself won
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			cap_q   <= CAP_RESET;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						result_q.out_priority  <= '0;
						result_q.out_treatment <= '0;
						result_q.out_tag       <= '0;
						result_q.fill_count    <= FILL_W'(WIDE_W'(cnt_q));
						if (request.command == CMD_PUSH) begin
							if (full) begin
								result_q.status <= ST_FULL;
								done_q          <= 1'b1;
							end else begin
								cnt_q           <= cnt_q + 1'b1;
								pos_q           <= cnt_q + 1'b1;
								cur_q.prio      <= request.entry_priority;
								cur_q.treatment <= request.entry_treatment;
								cur_q.tag       <= request.entry_tag;
								state_q         <= S_UP;
							end
						end else begin
							if (cnt_q == '0) begin
								result_q.status <= ST_EMPTY;
								done_q          <= 1'b1;
							end else begin
								state_q <= S_P_ROOT;
							end
						end
					end
				end
				S_UP: begin
					if (pos_q == CNT_W'(1)) begin
						result_q.status     <= ST_DONE;
						result_q.fill_count <= FILL_W'(WIDE_W'(cnt_q));
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end else begin
						state_q <= S_UP_C;
					end
				end
				S_UP_C: begin
					if (cmp_less) begin
						pos_q   <= parent;
						state_q <= S_UP;
					end else begin
						result_q.status     <= ST_DONE;
						result_q.fill_count <= FILL_W'(WIDE_W'(cnt_q));
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				S_P_ROOT: begin
					state_q <= S_P_LAST;
				end
				S_P_LAST: begin
					root_q  <= rdata;
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_P_MOVE;
				end
				S_P_MOVE: begin
					cur_q <= rdata;
					pos_q <= CNT_W'(1);
					if (cnt_q == '0) begin
						result_q.status        <= ST_DONE;
						result_q.out_priority  <= root_q.prio;
						result_q.out_treatment <= root_q.treatment;
						result_q.out_tag       <= root_q.tag;
						result_q.fill_count    <= '0;
						done_q                 <= 1'b1;
						state_q                <= S_IDLE;
					end else begin
						state_q <= S_DN;
					end
				end
				S_DN: begin
					if (has_left) begin
						state_q <= S_DN_LC;
					end else begin
						result_q.status        <= ST_DONE;
						result_q.out_priority  <= root_q.prio;
						result_q.out_treatment <= root_q.treatment;
						result_q.out_tag       <= root_q.tag;
						result_q.fill_count    <= FILL_W'(WIDE_W'(cnt_q));
						done_q                 <= 1'b1;
						state_q                <= S_IDLE;
					end
				end
				S_DN_LC: begin
					best_q      <= cmp_less ? rdata : cur_q;
					best_left_q <= cmp_less;
					if (has_right) begin
						state_q <= S_DN_RC;
					end else if (cmp_less) begin
						pos_q   <= CNT_W'(left_w);
						state_q <= S_DN;
					end else begin
						result_q.status        <= ST_DONE;
						result_q.out_priority  <= root_q.prio;
						result_q.out_treatment <= root_q.treatment;
						result_q.out_tag       <= root_q.tag;
						result_q.fill_count    <= FILL_W'(WIDE_W'(cnt_q));
						done_q                 <= 1'b1;
						state_q                <= S_IDLE;
					end
				end
				S_DN_RC: begin
					// right must be strictly smaller to beat the left winner
					if (cmp_less) begin
						pos_q   <= CNT_W'(right_w);
						state_q <= S_DN;
					end else if (best_left_q) begin
						pos_q   <= CNT_W'(left_w);
						state_q <= S_DN;
					end else begin
						result_q.status        <= ST_DONE;
						result_q.out_priority  <= root_q.prio;
						result_q.out_treatment <= root_q.treatment;
						result_q.out_tag       <= root_q.tag;
						result_q.fill_count    <= FILL_W'(WIDE_W'(cnt_q));
						done_q                 <= 1'b1;
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

	// every accepted transaction is either reported at once or keeps the block busy
	`TKMHQ_ASSERT_NXT(a_accept_progress, start && !busy, busy || done,
		"accepted transaction neither busy nor done")
	// a result is only strobed once the sequencer is back in idle
	`TKMHQ_ASSERT_IMP(a_done_idle, done, !busy, "result strobed while busy")
	// the store is written only while an item is being worked on
	`TKMHQ_ASSERT_IMP(a_write_busy, we, busy, "store written while idle")
	// empty pop reports no data and an empty queue
	`TKMHQ_ASSERT_IMP(a_empty_zero, done && result.status == ST_EMPTY,
		result.fill_count == '0 && result.out_tag == '0 && result.out_priority == '0,
		"empty pop with nonzero result")
	// the fill never passes the store depth
	`TKMHQ_ASSERT_IMP(a_cnt_bound, 1'b1, WIDE_W'(cnt_q) <= WIDE_W'(HEAP_DEPTH),
		"entry count above depth")

endmodule
